// ===== hdl/u2u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 text filter.
// Holds code-unit constants and the encoded-request type; no dependencies.
package u2u8_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW = 3;
  localparam int unsigned IdxW = 2;
  localparam int unsigned CpW = 21;

  // Surrogate tags in the top six bits of a code unit
  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag = 6'b110111;

  localparam logic [CpW-1:0] AstralBase = 21'h10000;
  localparam logic [CpW-1:0] FirstText = 21'h20;
  localparam logic [CpW-1:0] DelCode = 21'h7F;
  localparam logic [CpW-1:0] Lim1 = 21'h80;
  localparam logic [CpW-1:0] Lim2 = 21'h800;

  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] ContMark = 8'h80;

  // Up to four bytes of one code point, byte 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
  } enc_t;

endpackage

// ===== hdl/u2u8_if.sv =====
// Handshake channels for the text filter: code units in, UTF-8 bytes out.
// Depends on nothing.
interface u2u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

interface u2u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hdl/utf16_to_utf8_text_filter_top.sv =====
// UTF-16 to UTF-8 text filter, top level.
// A request passes the input and then the result register before its first byte.
// Throughput: one request per cycle while the result register is free or the unit
// is dropped; bytes leave one per cycle while the sink is ready and set the pace.
// Reset (rst, synchronous) drops any held high surrogate and pending bytes.
// Depends on u2u8_pkg, u2u8_if, u2u8_encode and u2u8_serial.
module utf16_to_utf8_text_filter_top
  import u2u8_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u2u8_unit_if.sink    unit_in,
  u2u8_byte_if.source  byte_out
);

  enc_t enc;
  logic enc_vld;
  logic res_free;

  // Pairing and encoding
  u2u8_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_in),
    .res_free (res_free),
    .enc_vld  (enc_vld),
    .enc      (enc)
  );

  // Byte output
  u2u8_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .enc_vld  (enc_vld),
    .enc      (enc),
    .res_free (res_free),
    .byte_out (byte_out)
  );

endmodule

// ===== hdl/u2u8_encode.sv =====
// Input register, surrogate pairing and UTF-8 encoding of one code point.
// Depends on u2u8_pkg and u2u8_unit_if.
module u2u8_encode
  import u2u8_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u2u8_unit_if.sink    unit_in,
  input  logic         res_free,
  output logic         enc_vld,
  output enc_t         enc
);

  logic             in_vld;
  logic [UnitW-1:0] in_unit;
  logic             held_valid;
  logic [9:0]       held_high_bits;

  logic             is_high;
  logic             is_low;
  logic             drop;
  logic [CpW-1:0]   cp;
  logic             advance;

  // Classify the unit and form the code point
  always_comb begin
    is_high = (in_unit[15:10] == HighTag);
    is_low  = (in_unit[15:10] == LowTag);
    if (is_low && held_valid) begin
      cp = {1'b0, held_high_bits, in_unit[9:0]} + AstralBase;
    end else begin
      cp = {{(CpW-UnitW){1'b0}}, in_unit};
    end
    drop = is_high || (is_low && !held_valid) || (cp < FirstText) || (cp == DelCode);
  end

  // UTF-8 byte layout
  always_comb begin
    enc.bytes = '0;
    if (drop) begin
      enc.cnt = '0;
    end else if (cp < Lim1) begin
      enc.cnt = CntW'(1);
      enc.bytes[0] = cp[7:0];
    end else if (cp < Lim2) begin
      enc.cnt = CntW'(2);
      enc.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      enc.bytes[1] = ContMark | {2'b00, cp[5:0]};
    end else if (cp < AstralBase) begin
      enc.cnt = CntW'(3);
      enc.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      enc.bytes[1] = ContMark | {2'b00, cp[11:6]};
      enc.bytes[2] = ContMark | {2'b00, cp[5:0]};
    end else begin
      enc.cnt = CntW'(4);
      enc.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      enc.bytes[1] = ContMark | {2'b00, cp[17:12]};
      enc.bytes[2] = ContMark | {2'b00, cp[11:6]};
      enc.bytes[3] = ContMark | {2'b00, cp[5:0]};
    end
  end

  // Requests with no bytes leave at once; others wait for a free result slot
  assign advance       = in_vld && ((enc.cnt == '0) || res_free);
  assign enc_vld       = in_vld && (enc.cnt != '0);
  assign unit_in.ready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (unit_in.ready) begin
      in_vld <= unit_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_in.valid && unit_in.ready) begin
      in_unit <= unit_in.code_unit;
    end
  end

  // Held high surrogate, updated as each request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else if (advance) begin
      if (is_high) begin
        held_valid     <= 1'b1;
        held_high_bits <= in_unit[9:0];
      end else begin
        held_valid     <= 1'b0;
        held_high_bits <= '0;
      end
    end
  end

endmodule

// ===== hdl/u2u8_serial.sv =====
// Result register that sends one code point's bytes one per cycle while the sink is ready.
// Depends on u2u8_pkg and u2u8_byte_if.
module u2u8_serial
  import u2u8_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         enc_vld,
  input  enc_t         enc,
  output logic         res_free,
  u2u8_byte_if.source  byte_out
);

  logic [MaxBytes-1:0][ByteW-1:0] res_bytes;
  logic [CntW-1:0]                res_cnt;
  logic [IdxW-1:0]                res_idx;
  logic                           take;
  logic                           load;

  assign take     = byte_out.valid && byte_out.ready;
  assign res_free = (res_cnt == '0) || ((res_cnt == CntW'(1)) && byte_out.ready);
  assign load     = enc_vld && res_free;

  assign byte_out.valid     = (res_cnt != '0);
  assign byte_out.out_byte  = res_bytes[res_idx];
  assign byte_out.last_byte = (res_cnt == CntW'(1));

  // Remaining count and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
      res_idx <= '0;
    end else if (load) begin
      res_cnt <= enc.cnt;
      res_idx <= '0;
    end else if (take) begin
      res_cnt <= res_cnt - CntW'(1);
      res_idx <= res_idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_bytes <= enc.bytes;
    end
  end

endmodule

// ===== hdl/u2u8_check.sv =====
// Port-level checks on the text filter's byte output, bound to the top level.
// Depends on utf16_to_utf8_text_filter_top.
module u2u8_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // A stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("stalled byte changed");

  // Nothing pending after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("byte valid after reset");

  // Rest of a code point follows without a gap
  a_nogap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("gap inside a code point");

  // Bytes after the lead byte are continuation bytes
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=> out_byte[7:6] == 2'b10)
    else $error("bad continuation byte");

endmodule

bind utf16_to_utf8_text_filter_top u2u8_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (byte_out.valid),
  .out_ready (byte_out.ready),
  .out_byte  (byte_out.out_byte),
  .last_byte (byte_out.last_byte)
);

// ===== sim/utf16_to_utf8_text_filter_top_test.sv =====
// Self-checking test of the UTF-16 to UTF-8 text filter top level.
// Depends on u2u8_pkg, u2u8_if and the filter RTL; code units in, predicted bytes checked.
module utf16_to_utf8_text_filter_top_test;
  import u2u8_pkg::*;

  localparam int unsigned RandomUnits = 85;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned MaxGap = 10;

  localparam logic [5:0] HighPrefix = 6'b110110;
  localparam logic [5:0] LowPrefix = 6'b110111;

  // Kinds of random code-unit sequences
  typedef enum int {
    MixPair, MixAscii, MixTwo, MixThree, MixControl,
    MixAny, MixOrphan, MixLost, MixReplace
  } mix_kind_e;

  typedef struct {
    logic [ByteW-1:0] out_byte;
    logic             last_byte;
  } utf8_byte_t;

  logic clk;
  logic rst;

  u2u8_unit_if unit_ch ();
  u2u8_byte_if byte_ch ();

  utf16_to_utf8_text_filter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_ch),
    .byte_out (byte_ch)
  );

  // Stimulus queues and expected byte stream
  logic [UnitW-1:0] unit_q[$];
  bit               drain_q[$];
  utf8_byte_t       utf8_q[$];

  // Predictor state
  logic [9:0] held_bits;
  bit         held_flag;

  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          send_burst;
  bit          recv_burst;
  int unsigned idle_cycles;
  bit          timed_out;
  int unsigned random_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void push_byte(input logic [7:0] b, input logic last);
    utf8_byte_t rec;
    rec.out_byte = b;
    rec.last_byte = last;
    utf8_q = {utf8_q, rec};
  endfunction

  // Expected UTF-8 bytes for one accepted code unit
  function automatic void encode_unit(input logic [UnitW-1:0] unit);
    logic [20:0] cp;
    cp = {5'd0, unit};
    if (unit[15:10] == HighPrefix) begin
      held_bits = unit[9:0];
      held_flag = 1'b1;
      return;
    end
    if (unit[15:10] == LowPrefix) begin
      // orphan low: dropped, state kept
      if (!held_flag) return;
      cp = 21'h10000 + {1'b0, held_bits, unit[9:0]};
    end
    held_bits = '0;
    held_flag = 1'b0;
    if (cp < 21'h20 || cp == 21'h7F) return;
    if (cp < 21'h80) begin
      push_byte(cp[7:0], 1'b1);
    end else if (cp < 21'h800) begin
      push_byte(8'hC0 | {3'd0, cp[10:6]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[5:0]}, 1'b1);
    end else if (cp < 21'h10000) begin
      push_byte(8'hE0 | {4'd0, cp[15:12]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[11:6]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[5:0]}, 1'b1);
    end else begin
      push_byte(8'hF0 | {5'd0, cp[20:18]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[17:12]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[11:6]}, 1'b0);
      push_byte(8'h80 | {2'd0, cp[5:0]}, 1'b1);
    end
  endfunction

  function automatic void add_unit(input logic [UnitW-1:0] unit, input bit drain);
    unit_q = {unit_q, unit};
    drain_q = {drain_q, drain};
  endfunction

  function automatic logic [UnitW-1:0] rand_high();
    return {HighPrefix, 10'($urandom_range(0, 1023))};
  endfunction

  function automatic logic [UnitW-1:0] rand_low();
    return {LowPrefix, 10'($urandom_range(0, 1023))};
  endfunction

  // Any unit that is neither control nor surrogate
  function automatic logic [UnitW-1:0] rand_plain();
    logic [UnitW-1:0] u;
    case ($urandom_range(0, 3))
      0: u = 16'($urandom_range(16'h20, 16'h7E));
      1: u = 16'($urandom_range(16'h80, 16'h7FF));
      2: u = 16'($urandom_range(16'h800, 16'hD7FF));
      default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
    return u;
  endfunction

  // Driver: one request in flight, gap drawn per item
  always @(posedge clk) begin
    if (rst) begin
      unit_ch.valid <= 1'b0;
      unit_ch.code_unit <= '0;
      send_gap = 0;
      send_burst = 1'b0;
      held_bits = '0;
      held_flag = 1'b0;
    end else begin
      if (unit_ch.valid && unit_ch.ready) begin
        encode_unit(unit_ch.code_unit);
        if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (!unit_ch.valid || unit_ch.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          unit_ch.valid <= 1'b0;
        end else if (unit_q.size() != 0 && !(drain_q[0] && utf8_q.size() != 0)) begin
          unit_ch.valid <= 1'b1;
          unit_ch.code_unit <= unit_q.pop_front();
          void'(drain_q.pop_front());
        end else begin
          unit_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall drawn per byte, compare with oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
      recv_stall = 0;
      recv_burst = 1'b0;
      mismatches = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (utf8_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("unexpected byte %02h last %0b", byte_ch.out_byte, byte_ch.last_byte);
        end else begin
          utf8_byte_t exp_rec;
          exp_rec = utf8_q.pop_front();
          if (byte_ch.out_byte !== exp_rec.out_byte ||
              byte_ch.last_byte !== exp_rec.last_byte) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                       exp_rec.out_byte, exp_rec.last_byte,
                       byte_ch.out_byte, byte_ch.last_byte);
          end
        end
        if ($urandom_range(0, 19) == 0) recv_burst = ~recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        byte_ch.ready <= 1'b0;
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      timed_out <= 1'b0;
    end else if ((unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) timed_out <= 1'b1;
    end
  end

  initial begin
    mix_kind_e   kind;
    int unsigned pick;
    random_count = 0;
    rst = 1'b1;

    // Directed: range edges, control codes, DEL
    add_unit(16'h0000, 1'b0);
    add_unit(16'h001F, 1'b0);
    add_unit(16'h0020, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'h007E, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b0);
    // lowest and highest astral code points; wait for the output to empty first
    add_unit(16'hD800, 1'b1);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    // a second high replaces the first
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    // low with nothing held
    add_unit(16'hDC00, 1'b0);
    // held high lost to a plain unit, then to a control code
    add_unit(16'hD83D, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'hD801, 1'b0);
    add_unit(16'h000A, 1'b0);
    add_unit(16'hDC00, 1'b0);

    // Random: mostly well-formed text, some broken sequences
    while (random_count < RandomUnits) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = MixPair;
      else if (pick < 40) kind = MixAscii;
      else if (pick < 55) kind = MixTwo;
      else if (pick < 68) kind = MixThree;
      else if (pick < 74) kind = MixControl;
      else if (pick < 84) kind = MixAny;
      else if (pick < 89) kind = MixOrphan;
      else if (pick < 94) kind = MixLost;
      else kind = MixReplace;
      case (kind)
        MixPair: begin
          add_unit(rand_high(), random_count == 0 || $urandom_range(0, 19) == 0);
          add_unit(rand_low(), 1'b0);
          random_count += 2;
        end
        MixAscii: begin
          add_unit(16'($urandom_range(16'h20, 16'h7E)), 1'b0);
          random_count += 1;
        end
        MixTwo: begin
          add_unit(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
          random_count += 1;
        end
        MixThree: begin
          if ($urandom_range(0, 1) == 0)
            add_unit(16'($urandom_range(16'h800, 16'hD7FF)), 1'b0);
          else
            add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0);
          random_count += 1;
        end
        MixControl: begin
          if ($urandom_range(0, 3) == 0) add_unit(16'h007F, 1'b0);
          else add_unit(16'($urandom_range(0, 16'h1F)), 1'b0);
          random_count += 1;
        end
        MixAny: begin
          add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
          random_count += 1;
        end
        MixOrphan: begin
          add_unit(rand_plain(), 1'b0);
          add_unit(rand_low(), 1'b0);
          random_count += 2;
        end
        MixLost: begin
          add_unit(rand_high(), 1'b0);
          add_unit(rand_plain(), 1'b0);
          random_count += 2;
        end
        default: begin
          add_unit(rand_high(), 1'b0);
          add_unit(rand_high(), 1'b0);
          add_unit(rand_low(), 1'b0);
          random_count += 3;
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for all requests and all bytes, then a quiet tail
    @(negedge clk);
    while (!timed_out && (unit_q.size() != 0 || unit_ch.valid || utf8_q.size() != 0))
      @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    if (utf8_q.size() != 0) begin
      $display("%0d expected bytes never arrived", utf8_q.size());
    end
    if (!timed_out && mismatches == 0 && utf8_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (timed_out) $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
